// ----- sv/bfq_pkg.sv -----
// constants shared by barcode_frame_qualifier, its port checker and testbench
// opcodes, status codes, register map and register reset values; no dependencies
package bfq_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_LEN_W = 7;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_EOF   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LONG      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_MIN_LEN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CS_LOW   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CS_HIGH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;

    localparam logic [CFG_LEN_W-1:0] RST_MIN_LEN  = 7'd1;
    localparam logic [CFG_LEN_W-1:0] RST_MAX_LEN  = 7'd64;
    localparam logic [BYTE_W-1:0]    RST_CS_LOW   = 8'd32;
    localparam logic [BYTE_W-1:0]    RST_CS_HIGH  = 8'd126;
    localparam logic [WIN_W-1:0]     RST_DEBOUNCE = 16'd1000;

endpackage

// ----- sv/barcode_frame_qualifier.sv -----
// barcode frame qualifier: leading/trailing trim, length and charset checks,
// duplicate suppression over a two-bank code memory; uses bfq_pkg
// data, tick and clear beats need no result slot.
// end of frame: early rejects (empty, short, long) go straight to the verdict
// state; otherwise the kept bytes pass through the memory read port (scan, drain,
// verdict), and an accepted code then leaves byte by byte (read, then load).
// no beat is taken from end of frame until its last result beat is loaded.
// reset (aresetn low, synchronous) restores configuration and control registers;
// code memory contents stay undefined and no result depends on an unwritten byte.
module barcode_frame_qualifier #(
    parameter int unsigned MAX_CODE_LEN = 64
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    input  logic [bfq_pkg::BYTE_W-1:0] s_tdata,  // data_byte
    input  logic [bfq_pkg::OP_W-1:0]   s_tuser,  // opcode

    output logic m_tvalid,
    input  logic m_tready,
    output logic [((bfq_pkg::BYTE_W + $clog2(MAX_CODE_LEN + 2) + 7) / 8) * 8 - 1:0]
                 m_tdata,                        // out_char, code_length, zero pad
    output logic [bfq_pkg::STATUS_W:0] m_tuser,  // status, has_char
    output logic m_tlast,                        // last_item

    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [bfq_pkg::PADDR_W-1:0] paddr,
    input  logic [bfq_pkg::PDATA_W-1:0] pwdata,
    output logic [bfq_pkg::PDATA_W-1:0] prdata,
    output logic pready
);

    localparam int unsigned LEN_W   = $clog2(MAX_CODE_LEN + 2);
    localparam int unsigned AW      = $clog2(MAX_CODE_LEN);
    localparam int unsigned TDATA_W = ((bfq_pkg::BYTE_W + LEN_W + 7) / 8) * 8;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_VERDICT = 3'd3;
    localparam logic [2:0] S_EMIT_RD = 3'd4;
    localparam logic [2:0] S_EMIT_LD = 3'd5;

    // configuration
    logic [bfq_pkg::CFG_LEN_W-1:0] min_len_reg, max_len_reg;
    logic [bfq_pkg::BYTE_W-1:0]    cs_low_reg, cs_high_reg;
    logic [bfq_pkg::WIN_W-1:0]     window_reg;

    // frame and control state
    logic [2:0]       state_reg, state_next;
    logic             bank_reg, bank_next;
    logic             leading_reg, leading_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] kept_reg, kept_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [LEN_W-1:0] last_len_reg, last_len_next;
    logic [bfq_pkg::WIN_W-1:0] elapsed_reg, elapsed_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [bfq_pkg::STATUS_W-1:0] st_reg, st_next;
    logic             bad_reg, bad_next;
    logic             diff_reg, diff_next;
    logic             rd_vld_reg;

    // result register
    logic                         out_vld_reg, out_vld_next;
    logic [bfq_pkg::STATUS_W-1:0] out_st_reg, out_st_next;
    logic                         out_has_reg, out_has_next;
    logic [bfq_pkg::BYTE_W-1:0]   out_char_reg, out_char_next;
    logic [LEN_W-1:0]             out_len_reg, out_len_next;
    logic                         out_last_reg, out_last_next;

    // code memory, one array per bank
    logic [bfq_pkg::BYTE_W-1:0] mem0 [MAX_CODE_LEN];
    logic [bfq_pkg::BYTE_W-1:0] mem1 [MAX_CODE_LEN];
    logic [bfq_pkg::BYTE_W-1:0] rd0_reg, rd1_reg;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;

    logic                       in_acc, cfg_wr, out_free;
    logic                       drop_byte;
    logic [bfq_pkg::BYTE_W-1:0] cur_byte, old_byte;
    logic [7:0]                 len8, limit8, max8;
    logic                       idx_last, dup;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign drop_byte = leading_reg && (s_tdata < bfq_pkg::CTRL_LIMIT);
    assign wr_en     = in_acc && (s_tuser == bfq_pkg::OP_DATA) && !drop_byte
                       && (pos_reg < LEN_W'(MAX_CODE_LEN));
    assign wr_addr   = pos_reg[AW-1:0];
    assign rd_addr   = idx_reg[AW-1:0];

    assign cur_byte = bank_reg ? rd1_reg : rd0_reg;
    assign old_byte = bank_reg ? rd0_reg : rd1_reg;

    assign len8     = 8'(kept_reg);
    assign max8     = 8'(max_len_reg);
    assign limit8   = (max8 < 8'(MAX_CODE_LEN)) ? max8 : 8'(MAX_CODE_LEN);
    assign idx_last = (idx_reg == LEN_W'(frame_len_reg - 1'b1));
    assign dup      = (last_len_reg != '0) && (last_len_reg == frame_len_reg)
                      && (elapsed_reg < window_reg) && !diff_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && !bank_reg) begin
            mem0[wr_addr] <= s_tdata;
        end
        if (wr_en && bank_reg) begin
            mem1[wr_addr] <= s_tdata;
        end
        rd0_reg <= mem0[rd_addr];
        rd1_reg <= mem1[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        leading_next   = leading_reg;
        pos_next       = pos_reg;
        kept_next      = kept_reg;
        frame_len_next = frame_len_reg;
        last_len_next  = last_len_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        st_next        = st_reg;
        bad_next       = bad_reg;
        diff_next      = diff_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_st_next    = out_st_reg;
        out_has_next   = out_has_reg;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        // fold the byte pair read last cycle into the scan flags
        if (rd_vld_reg) begin
            if (cur_byte < cs_low_reg || cur_byte > cs_high_reg) begin
                bad_next = 1'b1;
            end
            if (cur_byte != old_byte) begin
                diff_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        bfq_pkg::OP_DATA: begin
                            if (!drop_byte) begin
                                leading_next = 1'b0;
                                if (s_tdata > bfq_pkg::CTRL_LIMIT) begin
                                    kept_next = LEN_W'(pos_reg + 1'b1);
                                end
                                if (pos_reg <= LEN_W'(MAX_CODE_LEN)) begin
                                    pos_next = LEN_W'(pos_reg + 1'b1);
                                end
                            end
                        end
                        bfq_pkg::OP_EOF: begin
                            frame_len_next = kept_reg;
                            leading_next   = 1'b1;
                            pos_next       = '0;
                            kept_next      = '0;
                            idx_next       = '0;
                            bad_next       = 1'b0;
                            diff_next      = 1'b0;
                            if (kept_reg == '0) begin
                                st_next = bfq_pkg::ST_EMPTY;
                            end else if (len8 < 8'(min_len_reg)) begin
                                st_next = bfq_pkg::ST_SHORT;
                            end else if (len8 > limit8) begin
                                st_next = bfq_pkg::ST_LONG;
                            end else begin
                                st_next = bfq_pkg::ST_OK;
                            end
                            state_next = (st_next == bfq_pkg::ST_OK) ? S_SCAN : S_VERDICT;
                        end
                        bfq_pkg::OP_TICK: begin
                            if (elapsed_reg < window_reg) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                        end
                        default: begin
                            last_len_next = '0;
                            elapsed_next  = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                idx_next = LEN_W'(idx_reg + 1'b1);
                if (idx_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_VERDICT;
            end
            S_VERDICT: begin
                if (out_free) begin
                    out_has_next  = 1'b0;
                    out_char_next = '0;
                    out_len_next  = frame_len_reg;
                    out_last_next = 1'b1;
                    if (st_reg != bfq_pkg::ST_OK || bad_reg || dup) begin
                        out_vld_next = 1'b1;
                        if (st_reg != bfq_pkg::ST_OK) begin
                            out_st_next = st_reg;
                        end else if (bad_reg) begin
                            out_st_next = bfq_pkg::ST_INVALID;
                        end else begin
                            out_st_next = bfq_pkg::ST_DUPLICATE;
                        end
                        state_next = S_IDLE;
                    end else begin
                        last_len_next = frame_len_reg;
                        elapsed_next  = '0;
                        idx_next      = '0;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                // read is issued from idx every cycle; move on once the slot frees
                if (out_free) begin
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                out_vld_next  = 1'b1;
                out_st_next   = bfq_pkg::ST_OK;
                out_has_next  = 1'b1;
                out_char_next = cur_byte;
                out_len_next  = frame_len_reg;
                out_last_next = idx_last;
                idx_next      = LEN_W'(idx_reg + 1'b1);
                if (idx_last) begin
                    bank_next  = !bank_reg;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            leading_reg   <= 1'b1;
            pos_reg       <= '0;
            kept_reg      <= '0;
            frame_len_reg <= '0;
            last_len_reg  <= '0;
            elapsed_reg   <= '0;
            idx_reg       <= '0;
            st_reg        <= bfq_pkg::ST_OK;
            bad_reg       <= 1'b0;
            diff_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            leading_reg   <= leading_next;
            pos_reg       <= pos_next;
            kept_reg      <= kept_next;
            frame_len_reg <= frame_len_next;
            last_len_reg  <= last_len_next;
            elapsed_reg   <= elapsed_next;
            idx_reg       <= idx_next;
            st_reg        <= st_next;
            bad_reg       <= bad_next;
            diff_reg      <= diff_next;
            rd_vld_reg    <= (state_reg == S_SCAN);
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_st_reg   <= out_st_next;
        out_has_reg  <= out_has_next;
        out_char_reg <= out_char_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= bfq_pkg::RST_MIN_LEN;
            max_len_reg <= bfq_pkg::RST_MAX_LEN;
            cs_low_reg  <= bfq_pkg::RST_CS_LOW;
            cs_high_reg <= bfq_pkg::RST_CS_HIGH;
            window_reg  <= bfq_pkg::RST_DEBOUNCE;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                bfq_pkg::REG_MIN_LEN:  min_len_reg <= pwdata[bfq_pkg::CFG_LEN_W-1:0];
                bfq_pkg::REG_MAX_LEN:  max_len_reg <= pwdata[bfq_pkg::CFG_LEN_W-1:0];
                bfq_pkg::REG_CS_LOW:   cs_low_reg  <= pwdata[bfq_pkg::BYTE_W-1:0];
                bfq_pkg::REG_CS_HIGH:  cs_high_reg <= pwdata[bfq_pkg::BYTE_W-1:0];
                bfq_pkg::REG_DEBOUNCE: window_reg  <= pwdata[bfq_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            bfq_pkg::REG_MIN_LEN:  prdata = 32'(min_len_reg);
            bfq_pkg::REG_MAX_LEN:  prdata = 32'(max_len_reg);
            bfq_pkg::REG_CS_LOW:   prdata = 32'(cs_low_reg);
            bfq_pkg::REG_CS_HIGH:  prdata = 32'(cs_high_reg);
            bfq_pkg::REG_DEBOUNCE: prdata = 32'(window_reg);
            default:               prdata = '0;
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'({out_len_reg, out_char_reg});
    assign m_tuser  = {out_has_reg, out_st_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/bfq_checker.sv -----
// port-level checks on the barcode frame qualifier result channel
// uses bfq_pkg; bound to barcode_frame_qualifier below
module bfq_checker #(
    parameter int unsigned MAX_CODE_LEN = 64
) (
    input logic aclk,
    input logic aresetn,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((bfq_pkg::BYTE_W + $clog2(MAX_CODE_LEN + 2) + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [bfq_pkg::STATUS_W:0] m_tuser,
    input logic m_tlast
);

    localparam int unsigned LEN_W = $clog2(MAX_CODE_LEN + 2);

    // a stalled beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a status beat is a reject and closes the frame
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[bfq_pkg::STATUS_W] |->
            m_tlast && m_tuser[bfq_pkg::STATUS_W-1:0] != bfq_pkg::ST_OK)
        else $error("status beat without reject code or last flag");

    // a character beat belongs to an accepted code of sane length
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[bfq_pkg::STATUS_W] |->
            m_tuser[bfq_pkg::STATUS_W-1:0] == bfq_pkg::ST_OK
            && m_tdata[bfq_pkg::BYTE_W +: LEN_W] != '0
            && m_tdata[bfq_pkg::BYTE_W +: LEN_W] <= LEN_W'(MAX_CODE_LEN))
        else $error("character beat with bad status or length");

    // the code length stays fixed across the beats of one accepted code
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            $stable(m_tdata[bfq_pkg::BYTE_W +: LEN_W]) && m_tuser[bfq_pkg::STATUS_W])
        else $error("code length changed inside a code");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind barcode_frame_qualifier bfq_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_bfq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for barcode_frame_qualifier: directed frames, then random traffic
// predicts every result beat from its own model of the qualifier; depends on bfq_pkg
module tb_top;

    localparam int MAX_CODE_LEN  = 64;
    localparam int LEN_W         = $clog2(MAX_CODE_LEN + 2);
    localparam int AW            = $clog2(MAX_CODE_LEN);
    localparam int M_TDATA_W     = ((bfq_pkg::BYTE_W + LEN_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;

    typedef logic [bfq_pkg::BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        logic [bfq_pkg::STATUS_W-1:0] status;
        logic                         has_char;
        logic [bfq_pkg::BYTE_W-1:0]   out_char;
        logic [LEN_W-1:0]             code_len;
        logic                         last;
    } result_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bfq_pkg::BYTE_W-1:0]    s_tdata  = '0;
    logic [bfq_pkg::OP_W-1:0]      s_tuser  = bfq_pkg::OP_DATA;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [M_TDATA_W-1:0]          m_tdata;         // out_char, code_length, zero pad
    logic [bfq_pkg::STATUS_W:0]    m_tuser;         // status, has_char
    logic                          m_tlast;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [bfq_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [bfq_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [bfq_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // predictor state
    logic [bfq_pkg::CFG_LEN_W-1:0] cfg_min_len   = bfq_pkg::RST_MIN_LEN;
    logic [bfq_pkg::CFG_LEN_W-1:0] cfg_max_len   = bfq_pkg::RST_MAX_LEN;
    logic [bfq_pkg::BYTE_W-1:0]    cfg_cs_low    = bfq_pkg::RST_CS_LOW;
    logic [bfq_pkg::BYTE_W-1:0]    cfg_cs_high   = bfq_pkg::RST_CS_HIGH;
    logic [bfq_pkg::WIN_W-1:0]     cfg_window    = bfq_pkg::RST_DEBOUNCE;
    logic [bfq_pkg::BYTE_W-1:0]    code_mem [2][MAX_CODE_LEN];
    logic                          fill_bank     = 1'b0;
    logic                          skipping_lead = 1'b1;
    logic [LEN_W-1:0]              wr_pos        = '0;
    logic [LEN_W-1:0]              kept_len      = '0;
    logic [LEN_W-1:0]              prev_len      = '0;
    logic [bfq_pkg::WIN_W-1:0]     ms_count      = '0;

    result_beat_t pending_results[$];
    byte_q_t      last_body;
    int           mismatches    = 0;
    int           cycles        = 0;
    int           beats_sent    = 0;
    int           send_idle_pct = 6;
    int           recv_idle_pct = 58;
    logic         hold_on       = 1'b0;
    event         start_hold;

    barcode_frame_qualifier #(.MAX_CODE_LEN(MAX_CODE_LEN)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // end of frame: trim is already in kept_len, run the checks in order
    task automatic close_frame();
        logic [LEN_W-1:0]             len;
        logic [LEN_W-1:0]             limit;
        logic [bfq_pkg::STATUS_W-1:0] st;
        logic                         same;
        len   = kept_len;
        limit = (cfg_max_len < MAX_CODE_LEN) ? cfg_max_len : LEN_W'(MAX_CODE_LEN);
        st    = bfq_pkg::ST_OK;
        skipping_lead = 1'b1;
        wr_pos        = '0;
        kept_len      = '0;
        if (len == 0) begin
            st = bfq_pkg::ST_EMPTY;
        end else if (len < cfg_min_len) begin
            st = bfq_pkg::ST_SHORT;
        end else if (len > limit) begin
            st = bfq_pkg::ST_LONG;
        end else begin
            for (int i = 0; i < len; i++) begin
                if (code_mem[fill_bank][i] < cfg_cs_low || code_mem[fill_bank][i] > cfg_cs_high)
                    st = bfq_pkg::ST_INVALID;
            end
        end
        if (st == bfq_pkg::ST_OK && prev_len != 0 && prev_len == len
            && ms_count < cfg_window) begin
            same = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (code_mem[fill_bank][i] != code_mem[!fill_bank][i])
                    same = 1'b0;
            end
            if (same)
                st = bfq_pkg::ST_DUPLICATE;
        end
        if (st != bfq_pkg::ST_OK) begin
            pending_results.push_back(result_beat_t'{st, 1'b0, '0, len, 1'b1});
        end else begin
            for (int i = 0; i < len; i++)
                pending_results.push_back(result_beat_t'{bfq_pkg::ST_OK, 1'b1,
                                                         code_mem[fill_bank][i],
                                                         len, (i + 1 == len)});
            prev_len  = len;
            ms_count  = '0;
            fill_bank = !fill_bank;
        end
    endtask

    task automatic qualify_beat(input logic [bfq_pkg::OP_W-1:0] op,
                                input logic [bfq_pkg::BYTE_W-1:0] b);
        case (op)
            bfq_pkg::OP_DATA: begin
                if (!(skipping_lead && b < bfq_pkg::CTRL_LIMIT)) begin
                    skipping_lead = 1'b0;
                    if (wr_pos < MAX_CODE_LEN)
                        code_mem[fill_bank][wr_pos[AW-1:0]] = b;
                    if (b > bfq_pkg::CTRL_LIMIT)
                        kept_len = wr_pos + 1'b1;
                    if (wr_pos <= MAX_CODE_LEN)
                        wr_pos++;
                end
            end
            bfq_pkg::OP_EOF: close_frame();
            bfq_pkg::OP_TICK: begin
                if (ms_count < cfg_window)
                    ms_count++;
            end
            default: begin
                prev_len = '0;
                ms_count = '0;
            end
        endcase
    endtask

    // result side: check each beat taken, then decide tready for the next cycle
    always @(posedge aclk) begin
        result_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[bfq_pkg::STATUS_W-1:0] != want.status)
                    report_mismatch("status", int'(m_tuser[bfq_pkg::STATUS_W-1:0]),
                                    int'(want.status));
                if (m_tuser[bfq_pkg::STATUS_W] != want.has_char)
                    report_mismatch("has_char", int'(m_tuser[bfq_pkg::STATUS_W]),
                                    int'(want.has_char));
                if (m_tdata[bfq_pkg::BYTE_W-1:0] != want.out_char)
                    report_mismatch("out_char", int'(m_tdata[bfq_pkg::BYTE_W-1:0]),
                                    int'(want.out_char));
                if (m_tdata[bfq_pkg::BYTE_W +: LEN_W] != want.code_len)
                    report_mismatch("code_length", int'(m_tdata[bfq_pkg::BYTE_W +: LEN_W]),
                                    int'(want.code_len));
                if (m_tlast != want.last)
                    report_mismatch("last_item", int'(m_tlast), int'(want.last));
            end
        end
        m_tready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial forever begin
        @(start_hold);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    task automatic send_beat(input logic [bfq_pkg::OP_W-1:0] op,
                             input logic [bfq_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= bfq_pkg::BYTE_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        qualify_beat(op, b);
    endtask

    task automatic send_op(input logic [bfq_pkg::OP_W-1:0] op);
        send_beat(op, bfq_pkg::BYTE_W'($urandom));
    endtask

    task automatic send_frame(input byte_q_t body, input int lead, input int trail);
        repeat (lead) send_beat(bfq_pkg::OP_DATA, bfq_pkg::BYTE_W'($urandom_range(31)));
        foreach (body[i]) send_beat(bfq_pkg::OP_DATA, body[i]);
        repeat (trail) send_beat(bfq_pkg::OP_DATA, bfq_pkg::BYTE_W'($urandom_range(32)));
        send_op(bfq_pkg::OP_EOF);
        last_body = body;
    endtask

    // input idle until every expected beat is out and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bfq_pkg::REG_IDX_W-1:0] idx,
                             input logic [bfq_pkg::PDATA_W-1:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bfq_pkg::REG_MIN_LEN:  cfg_min_len = val[bfq_pkg::CFG_LEN_W-1:0];
            bfq_pkg::REG_MAX_LEN:  cfg_max_len = val[bfq_pkg::CFG_LEN_W-1:0];
            bfq_pkg::REG_CS_LOW:   cfg_cs_low  = val[bfq_pkg::BYTE_W-1:0];
            bfq_pkg::REG_CS_HIGH:  cfg_cs_high = val[bfq_pkg::BYTE_W-1:0];
            bfq_pkg::REG_DEBOUNCE: cfg_window  = val[bfq_pkg::WIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int min_len, input int max_len, input int cs_low,
                              input int cs_high, input int window);
        write_reg(bfq_pkg::REG_MIN_LEN, min_len);
        write_reg(bfq_pkg::REG_MAX_LEN, max_len);
        write_reg(bfq_pkg::REG_CS_LOW, cs_low);
        write_reg(bfq_pkg::REG_CS_HIGH, cs_high);
        write_reg(bfq_pkg::REG_DEBOUNCE, window);
    endtask

    function automatic byte_q_t make_body(input int n);
        byte_q_t body;
        for (int i = 0; i < n; i++)
            body.push_back(($urandom_range(99) < 94)
                           ? bfq_pkg::BYTE_W'($urandom_range(8'h21, 8'h7e))
                           : bfq_pkg::BYTE_W'($urandom_range(255)));
        return body;
    endfunction

    task automatic test_trim_and_empty();
        send_op(bfq_pkg::OP_EOF);
        send_frame('{8'h00, 8'h41, 8'h0a}, 0, 0);   // leading control dropped, trailing trimmed
        send_frame('{8'h20}, 0, 0);                 // space only: kept nothing
    endtask

    task automatic test_charset_bounds();
        write_reg(bfq_pkg::REG_CS_LOW, 32'h41);
        write_reg(bfq_pkg::REG_CS_HIGH, 32'hff);
        send_frame('{8'hff}, 0, 0);
        send_frame('{8'h40}, 0, 0);
    endtask

    task automatic test_length_bounds();
        write_reg(bfq_pkg::REG_MIN_LEN, 2);
        write_reg(bfq_pkg::REG_MAX_LEN, 3);
        send_frame('{8'h61}, 0, 0);
        send_frame('{8'h61, 8'h62, 8'h63, 8'h64}, 0, 0);
        write_reg(bfq_pkg::REG_MIN_LEN, 1);
        write_reg(bfq_pkg::REG_MAX_LEN, 127);
    endtask

    task automatic test_debounce_window();
        write_reg(bfq_pkg::REG_DEBOUNCE, 2);
        send_frame('{8'hff}, 0, 0);                 // same as last accepted code: suppressed
        repeat (2) send_op(bfq_pkg::OP_TICK);
        send_frame('{8'hff}, 0, 0);                 // window elapsed
        send_op(bfq_pkg::OP_CLEAR);
        send_frame('{8'hff}, 0, 0);                 // no last code after clear
        write_reg(bfq_pkg::REG_DEBOUNCE, 32'hffff);
        repeat (3) send_op(bfq_pkg::OP_TICK);
        write_reg(bfq_pkg::REG_DEBOUNCE, 1);        // window now below the count
        send_frame('{8'hff}, 0, 0);
    endtask

    task automatic test_backpressure();
        set_config(1, 127, 0, 255, 0);
        -> start_hold;
        repeat (6) send_frame(make_body($urandom_range(4, 10)), 0, 0);
        settle();
        repeat (3) send_frame(make_body($urandom_range(4, 10)), 1, 1);
    endtask

    task automatic random_config();
        set_config(($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(1, 127),
                   ($urandom_range(99) < 30) ? 127 : $urandom_range(4, 64),
                   ($urandom_range(99) < 70) ? $urandom_range(0, 8'h30) : $urandom_range(255),
                   ($urandom_range(99) < 70) ? $urandom_range(8'h70, 8'hff) : $urandom_range(255),
                   ($urandom_range(99) < 70) ? $urandom_range(0, 12)
                       : (($urandom_range(99) < 50) ? 32'hffff : $urandom_range(16'hffff)));
    endtask

    task automatic random_items(input int n);
        int      first;
        int      pick;
        int      len;
        byte_q_t body;
        first = beats_sent;
        while (beats_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                if (pick < 15 && last_body.size() != 0) begin
                    body = last_body;               // repeat to provoke duplicates
                end else begin
                    len  = ($urandom_range(99) < 8) ? $urandom_range(60, 68)
                                                    : $urandom_range(1, 10);
                    body = make_body(len);
                end
                send_frame(body, $urandom_range(0, 2), $urandom_range(0, 2));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) send_op(bfq_pkg::OP_TICK);
            end else if (pick < 80) begin
                send_op(bfq_pkg::OP_CLEAR);
            end else if (pick < 88) begin
                repeat ($urandom_range(0, 2))
                    send_beat(bfq_pkg::OP_DATA, bfq_pkg::BYTE_W'($urandom_range(32)));
                send_op(bfq_pkg::OP_EOF);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_beat(bfq_pkg::OP_W'($urandom), bfq_pkg::BYTE_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 58 : 0;
            recv_idle_pct = (phase < 2) ? 58 : (phase < 4) ? 6 : 0;
            case (phase)
                0:       set_config(1, 127, 0, 255, 0);
                3:       set_config(64, 64, 32'h21, 32'h7e, 32'hffff);
                default: random_config();
            endcase
            random_items(35);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_trim_and_empty();
        test_charset_bounds();
        test_length_bounds();
        test_debounce_window();
        test_backpressure();
        test_random_traffic();
        settle();
        if (pending_results.size() != 0)
            report_mismatch("missing beats", 0, pending_results.size());
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bfq_pkg.sv
sv/barcode_frame_qualifier.sv
sv/bfq_checker.sv
tb/tb_top.sv
